// ===== rtl/usplit_pkg.sv =====
// ----------------------------------------------------------------------------
// usplit_pkg: shared types and constants of the URL path splitter
// Item classification record, queue sizing and the character codes used
// by the front end.
// ----------------------------------------------------------------------------
package usplit_pkg;

	// default bound on the kept path length
	localparam int DEF_MAX_LENGTH = 4096;

	// queue between front and back, power of two
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// result field widths
	localparam int POS_W = 13;
	localparam int LEN_W = 14;
	localparam int OUT_W = 136;

	// character codes
	localparam logic [7:0] CH_QUERY = 8'h3F;	// '?'
	localparam logic [7:0] CH_HASH  = 8'h23;	// '#'
	localparam logic [7:0] CH_SLASH = 8'h2F;	// '/'
	localparam logic [7:0] CH_DOT   = 8'h2E;	// '.'

	// one classified item
	typedef struct packed {
		logic is_query;
		logic is_hash;
		logic is_slash;
		logic is_dot;
		logic last;
		logic empty;
	} entry_t;

endpackage

// ===== rtl/url_path_component_splitter_top.sv =====
// ----------------------------------------------------------------------------
// url_path_component_splitter_top: URL path part splitter
// Splits a byte stream path into file path, query, fragment, directory,
// basename and extension positions and lengths.
//
//   channel | dir | payload
//   s_*     | in  | tdata = path_byte, tlast = last_byte, tuser = empty_path
//   m_*     | out | tdata = one result per closed path
//
// One item is accepted per cycle while the queue has room; the scan state
// updates once per item, and that loop sets the rate. m_tvalid rises once
// the closing item has passed queue write, snapshot and output register.
// Reset clears queue, scan state and valid flags; no clearing pass.
// A stalled output holds the snapshot stage, then the back end, then the
// queue fills and s_tready drops.
// ----------------------------------------------------------------------------
module url_path_component_splitter_top #(
	parameter int MAX_LENGTH = usplit_pkg::DEF_MAX_LENGTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,	// path_byte[7:0]
	input  logic                          s_tlast,	// last_byte
	input  logic                          s_tuser,	// empty_path
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// filepath_len[13:0], query_pos[26:14], query_len[40:27], ref_pos[53:41],
	// ref_len[67:54], directory_len[81:68], basename_pos[94:82],
	// basename_len[107:95], extension_pos[120:108], extension_len[134:121],
	// too_long[135]
	output logic [usplit_pkg::OUT_W-1:0]  m_tdata
);
	import usplit_pkg::*;

	logic   q_full;
	logic   q_push;
	logic   q_valid;
	logic   q_pop;
	entry_t push_entry;
	entry_t head_entry;

	usplit_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	usplit_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.valid      (q_valid),
		.head       (head_entry),
		.pop        (q_pop)
	);

	usplit_back #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (head_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== rtl/usplit_front.sv =====
// ----------------------------------------------------------------------------
// usplit_front: input side of the URL path splitter
// Accepts path bytes and reduces each one to its class flags for the queue.
// ----------------------------------------------------------------------------
module usplit_front (
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,	// path_byte[7:0]
	input  logic                s_tlast,
	input  logic                s_tuser,	// empty_path
	input  logic                q_full,
	output logic                q_push,
	output usplit_pkg::entry_t  q_entry
);
	import usplit_pkg::*;

	// accept while the queue has room
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// byte classification
	always_comb begin
		q_entry.is_query = (s_tdata == CH_QUERY);
		q_entry.is_hash  = (s_tdata == CH_HASH);
		q_entry.is_slash = (s_tdata == CH_SLASH);
		q_entry.is_dot   = (s_tdata == CH_DOT);
		q_entry.last     = s_tlast;
		q_entry.empty    = s_tuser;
	end

endmodule

// ===== rtl/usplit_fifo.sv =====
// ----------------------------------------------------------------------------
// usplit_fifo: short queue of classified items
// Decouples the front end from the back end so each can stall alone.
// ----------------------------------------------------------------------------
module usplit_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  usplit_pkg::entry_t  push_entry,
	output logic                full,
	output logic                valid,
	output usplit_pkg::entry_t  head,
	input  logic                pop
);
	import usplit_pkg::*;

	entry_t              mem [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_wr;
	logic                do_rd;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign valid = (count_q != '0);
	assign head  = mem[rd_ptr_q];
	assign do_wr = push && !full;
	assign do_rd = pop && valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue fill level beyond depth");

endmodule

// ===== rtl/usplit_back.sv =====
// ----------------------------------------------------------------------------
// usplit_back: scanning state and result stage of the URL path splitter
// Tracks delimiter positions per item, snapshots them when a path closes
// and works out the part positions and lengths into the output register.
// ----------------------------------------------------------------------------
module usplit_back #(
	parameter int MAX_LENGTH = usplit_pkg::DEF_MAX_LENGTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  usplit_pkg::entry_t            q_entry,
	output logic                          q_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [usplit_pkg::OUT_W-1:0]  m_tdata
);
	import usplit_pkg::*;

	// position width holds MAX_LENGTH + 1; compute width covers field widths
	localparam int PW = $clog2(MAX_LENGTH + 2);
	localparam int XW = (PW + 1 > LEN_W) ? PW + 1 : LEN_W;

	typedef struct packed {
		logic [PW-1:0] cnt;
		logic [PW-1:0] qstart;
		logic          qfound;
		logic [PW-1:0] fstart;
		logic          ffound;
		logic [PW-1:0] slash_at;
		logic          sfound;
		logic [PW-1:0] dot_at;
		logic          dfound;
		logic          rdot0;	// last file path byte was a dot
		logic          rdot1;	// the one before it was a dot
		logic          ovf;
	} scan_t;

	scan_t    st_q;
	scan_t    st_d;
	scan_t    snap_s1;
	logic     snap_v_s1;
	logic     snap_ready;
	logic     take;
	logic     closing;
	logic     in_path;
	logic     out_v_q;
	logic [OUT_W-1:0] out_q;

	// ---- scan update
	assign closing = q_entry.last || q_entry.empty;
	assign q_pop   = q_valid && (!closing || snap_ready);
	assign in_path = !st_q.qfound && !st_q.ffound && !q_entry.is_query && !q_entry.is_hash;

	always_comb begin
		st_d = st_q;
		if (!q_entry.empty) begin
			if (st_q.cnt >= PW'(MAX_LENGTH)) begin
				st_d.ovf = 1'b1;
			end else begin
				if (in_path) begin
					if (q_entry.is_slash) begin
						st_d.slash_at = st_q.cnt;
						st_d.sfound   = 1'b1;
					end
					if (q_entry.is_dot) begin
						st_d.dot_at = st_q.cnt;
						st_d.dfound = 1'b1;
					end
					st_d.rdot1 = st_q.rdot0;
					st_d.rdot0 = q_entry.is_dot;
				end
				if (!st_q.ffound) begin
					if (!st_q.qfound && q_entry.is_query) begin
						st_d.qfound = 1'b1;
						st_d.qstart = st_q.cnt + 1'b1;
					end else if (q_entry.is_hash) begin
						st_d.ffound = 1'b1;
						st_d.fstart = st_q.cnt + 1'b1;
					end
				end
				st_d.cnt = st_q.cnt + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (q_pop) begin
			st_q <= closing ? '0 : st_d;
		end
	end

	// ---- snapshot of a closed path
	assign take       = snap_v_s1 && (!out_v_q || m_tready);
	assign snap_ready = !snap_v_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_v_s1 <= 1'b0;
		end else if (q_pop && closing) begin
			snap_v_s1 <= 1'b1;
		end else if (take) begin
			snap_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && closing) begin
			snap_s1 <= st_d;
		end
	end

	// ---- part positions and lengths
	logic [XW-1:0] n, qs, fs, sl, dt, e, fst, blen;
	logic [XW-1:0] fp_len, q_pos, q_len, r_pos, r_len, d_len, x_pos, x_len, b_len;
	logic          dir_whole;
	logic          has_ext;

	always_comb begin
		n  = XW'(snap_s1.cnt);
		qs = XW'(snap_s1.qstart);
		fs = XW'(snap_s1.fstart);
		sl = XW'(snap_s1.slash_at);
		dt = XW'(snap_s1.dot_at);

		// end of the file path
		if (snap_s1.qfound) e = qs - 1'b1;
		else if (snap_s1.ffound) e = fs - 1'b1;
		else e = n;

		q_pos = snap_s1.qfound ? qs : '0;
		if (!snap_s1.qfound) q_len = '1;
		else if (snap_s1.ffound) q_len = fs - 1'b1 - qs;
		else q_len = n - qs;

		r_pos = snap_s1.ffound ? fs : '0;
		r_len = snap_s1.ffound ? n - fs : '1;

		// trailing "/." or "/.." keeps the whole file path as directory
		dir_whole = snap_s1.sfound &&
			(((sl + XW'(2)) == e && snap_s1.rdot0) ||
			 ((sl + XW'(3)) == e && snap_s1.rdot0 && snap_s1.rdot1));

		if (!snap_s1.sfound) begin
			d_len = '1;
			fst   = '0;
		end else if (dir_whole) begin
			d_len = e;
			fst   = e;
		end else begin
			d_len = sl + 1'b1;
			fst   = sl + 1'b1;
		end

		blen    = e - fst;
		has_ext = !dir_whole && (e != fst) && snap_s1.dfound && (dt > fst) &&
			((dt + 1'b1) < e);
		b_len   = has_ext ? dt - fst : blen;
		x_pos   = has_ext ? dt + 1'b1 : '0;
		x_len   = has_ext ? e - dt - 1'b1 : '1;
		fp_len  = (e == '0) ? '1 : e;
	end

	// ---- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (take) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= {snap_s1.ovf,
				x_len[LEN_W-1:0], x_pos[POS_W-1:0], b_len[POS_W-1:0],
				fst[POS_W-1:0], d_len[LEN_W-1:0], r_len[LEN_W-1:0],
				r_pos[POS_W-1:0], q_len[LEN_W-1:0], q_pos[POS_W-1:0],
				fp_len[LEN_W-1:0]};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	// ---- checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.cnt <= PW'(MAX_LENGTH))
		else $error("byte count beyond bound");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.ovf |-> st_q.cnt == PW'(MAX_LENGTH))
		else $error("overflow without full count");

	a_query_pos: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.qfound |-> (st_q.qstart != '0) && (st_q.qstart <= st_q.cnt))
		else $error("query start out of range");

	a_frag_after_query: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.qfound && st_q.ffound) |-> st_q.fstart > st_q.qstart)
		else $error("fragment before query");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(snap_v_s1 && !take) |=> snap_v_s1 && $stable(snap_s1))
		else $error("pending snapshot lost");

endmodule

// ===== verif/tb_url_path_component_splitter_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_url_path_component_splitter_top: self-checking bench for the splitter
// Streams URL paths into the block byte by byte and scores every result
// against a local scan model: short directed paths for the corner cases,
// then random paths under several sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_url_path_component_splitter_top;
	import usplit_pkg::*;

	localparam int PATH_MAX = DEF_MAX_LENGTH;
	localparam int DRAIN_CYCLES = 10;

	// one input item
	typedef struct {
		logic [7:0] ch;
		logic       last;
		logic       empty;
	} path_item_t;

	// one result, packed to match m_tdata (first member is the MSB)
	typedef struct packed {
		logic                    too_long;
		logic signed [LEN_W-1:0] extension_len;
		logic [POS_W-1:0]        extension_pos;
		logic [POS_W-1:0]        basename_len;
		logic [POS_W-1:0]        basename_pos;
		logic signed [LEN_W-1:0] directory_len;
		logic signed [LEN_W-1:0] ref_len;
		logic [POS_W-1:0]        ref_pos;
		logic signed [LEN_W-1:0] query_len;
		logic [POS_W-1:0]        query_pos;
		logic signed [LEN_W-1:0] filepath_len;
	} split_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;	// path_byte[7:0]
	logic             s_tlast = 1'b0;	// last_byte
	logic             s_tuser = 1'b0;	// empty_path
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;	// see the port list of the block for the layout

	path_item_t pending_items[$];
	split_t     split_q[$];
	logic [7:0] run_buf[$];
	logic       in_fire = 1'b0;
	int         send_idle = 0;
	int         recv_stall = 0;
	int         items_queued = 0;
	int         errors = 0;

	// scan state of the local model
	int          scan_cnt, q_at, h_at, slash_at, dot_at;
	bit          q_seen, h_seen, slash_seen, dot_seen, ovf;
	logic [15:0] tail2;

	url_path_component_splitter_top #(.MAX_LENGTH(PATH_MAX)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model

	function automatic void path_clear();
		scan_cnt = 0; q_at = 0; h_at = 0; slash_at = 0; dot_at = 0;
		q_seen = 0; h_seen = 0; slash_seen = 0; dot_seen = 0; ovf = 0;
		tail2 = '0;
	endfunction

	function automatic void path_scan_byte(logic [7:0] ch);
		if (scan_cnt >= PATH_MAX) begin
			ovf = 1;
			return;
		end
		// file path part only: track separators and the last two bytes
		if (!q_seen && !h_seen && ch != CH_QUERY && ch != CH_HASH) begin
			if (ch == CH_SLASH) begin
				slash_at = scan_cnt;
				slash_seen = 1;
			end
			if (ch == CH_DOT) begin
				dot_at = scan_cnt;
				dot_seen = 1;
			end
			tail2 = {tail2[7:0], ch};
		end
		// first '?' before any '#' opens the query, first '#' the fragment
		if (!h_seen) begin
			if (!q_seen && ch == CH_QUERY) begin
				q_seen = 1;
				q_at = scan_cnt + 1;
			end else if (ch == CH_HASH) begin
				h_seen = 1;
				h_at = scan_cnt + 1;
			end
		end
		scan_cnt++;
	endfunction

	function automatic split_t path_close();
		split_t r;
		int     fp_end, fstart;
		bit     dir_whole;
		r = '0;
		r.query_len = '1;
		r.ref_len = '1;
		r.directory_len = '1;
		r.extension_len = '1;
		if (q_seen) begin
			r.query_pos = POS_W'(q_at);
			r.query_len = LEN_W'(h_seen ? h_at - 1 - q_at : scan_cnt - q_at);
		end
		if (h_seen) begin
			r.ref_pos = POS_W'(h_at);
			r.ref_len = LEN_W'(scan_cnt - h_at);
		end
		fp_end = q_seen ? q_at - 1 : (h_seen ? h_at - 1 : scan_cnt);
		fstart = 0;
		dir_whole = 0;
		if (slash_seen) begin
			// trailing "/." or "/.." belongs wholly to the directory
			if (slash_at + 2 == fp_end && tail2[7:0] == CH_DOT)
				dir_whole = 1;
			if (slash_at + 3 == fp_end && tail2 == {CH_DOT, CH_DOT})
				dir_whole = 1;
			fstart = dir_whole ? fp_end : slash_at + 1;
			r.directory_len = LEN_W'(fstart);
		end
		r.basename_pos = POS_W'(fstart);
		r.basename_len = POS_W'(fp_end - fstart);
		// extension needs a dot inside the name, not leading and not trailing
		if (!dir_whole && fp_end > fstart && dot_seen && dot_at > fstart &&
				dot_at + 1 < fp_end) begin
			r.basename_len = POS_W'(dot_at - fstart);
			r.extension_pos = POS_W'(dot_at + 1);
			r.extension_len = LEN_W'(fp_end - dot_at - 1);
		end
		r.filepath_len = (fp_end == 0) ? '1 : LEN_W'(fp_end);
		r.too_long = ovf;
		return r;
	endfunction

	// ------------------------------------------------------------- stimulus

	task automatic push_item(logic [7:0] ch, logic last, logic empty);
		path_item_t it;
		it.ch = ch;
		it.last = last;
		it.empty = empty;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// send run_buf as one path, closed by its last byte or by an empty item
	task automatic flush_run(bit via_empty);
		int n;
		n = run_buf.size();
		if (via_empty || n == 0) begin
			foreach (run_buf[i])
				push_item(run_buf[i], 1'b0, 1'b0);
			push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
		end else begin
			foreach (run_buf[i])
				push_item(run_buf[i], i == n - 1, 1'b0);
		end
		run_buf.delete();
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			run_buf.push_back(s[i]);
		flush_run(1'b0);
	endtask

	task automatic add_token();
		case ($urandom_range(0, 9))
			0, 1: run_buf.push_back(CH_SLASH);
			2: run_buf.push_back(CH_DOT);
			3: begin
				run_buf.push_back(CH_DOT);
				run_buf.push_back(CH_DOT);
			end
			4: repeat ($urandom_range(1, 3))
				run_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
			5: begin
				run_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
				run_buf.push_back(CH_DOT);
				run_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
			end
			6: run_buf.push_back(CH_QUERY);
			7: run_buf.push_back(CH_HASH);
			8: run_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
			default: begin
				run_buf.push_back(CH_SLASH);
				run_buf.push_back(CH_DOT);
			end
		endcase
	endtask

	task automatic gen_random_path();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 75) begin
			// token-built path
			repeat ($urandom_range(0, 7)) add_token();
			flush_run(1'b0);
		end else if (kind < 90) begin
			// raw bytes
			repeat ($urandom_range(1, 8)) run_buf.push_back(8'($urandom_range(0, 255)));
			flush_run(1'b0);
		end else begin
			// closed by the empty flag
			repeat ($urandom_range(0, 4)) add_token();
			flush_run(1'b1);
		end
	endtask

	task automatic fill_random(int n);
		int stop_at;
		stop_at = items_queued + n;
		while (items_queued < stop_at)
			gen_random_path();
	endtask

	// hold off until every item is sent and every result has come back
	task automatic wait_drained();
		while (pending_items.size() != 0 || s_tvalid || split_q.size() != 0)
			@(negedge clk);
	endtask

	// --------------------------------------------------------------- driver

	always @(negedge clk) begin : drive
		path_item_t it;
		logic       show;
		show = s_tvalid && !in_fire;
		if (arst_n && !show && pending_items.size() != 0 &&
				$urandom_range(0, 99) >= send_idle) begin
			it = pending_items.pop_front();
			s_tdata <= it.ch;
			s_tlast <= it.last;
			s_tuser <= it.empty;
			show = 1'b1;
		end
		s_tvalid <= show;
		m_tready <= arst_n && ($urandom_range(0, 99) >= recv_stall);
	end

	// -------------------------------------------------------------- monitor

	task automatic check_field(string fname, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : watch
		split_t want, got;
		in_fire <= s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			got = split_t'(m_tdata);
			if (split_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
				errors++;
			end else begin
				want = split_q.pop_front();
				check_field("filepath_len", int'($signed(want.filepath_len)),
					int'($signed(got.filepath_len)));
				check_field("query_pos", int'(want.query_pos), int'(got.query_pos));
				check_field("query_len", int'($signed(want.query_len)),
					int'($signed(got.query_len)));
				check_field("ref_pos", int'(want.ref_pos), int'(got.ref_pos));
				check_field("ref_len", int'($signed(want.ref_len)),
					int'($signed(got.ref_len)));
				check_field("directory_len", int'($signed(want.directory_len)),
					int'($signed(got.directory_len)));
				check_field("basename_pos", int'(want.basename_pos),
					int'(got.basename_pos));
				check_field("basename_len", int'(want.basename_len),
					int'(got.basename_len));
				check_field("extension_pos", int'(want.extension_pos),
					int'(got.extension_pos));
				check_field("extension_len", int'($signed(want.extension_len)),
					int'($signed(got.extension_len)));
				check_field("too_long", int'(want.too_long), int'(got.too_long));
			end
		end
		// accepted input item updates the scan model
		if (arst_n && s_tvalid && s_tready) begin
			if (!s_tuser)
				path_scan_byte(s_tdata);
			if (s_tlast || s_tuser) begin
				split_q.push_back(path_close());
				path_clear();
			end
		end
	end

	// ------------------------------------------------------------- sequence

	initial begin
		path_clear();
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// phase 1: no idling, directed corner cases first
		send_idle = 0;
		recv_stall = 0;
		push_text("/a.b");
		push_text("/..");
		push_text("x/.");
		push_text(".rc");
		push_text("a.");
		push_text("d/");
		push_text("?q#r");
		push_text("#x?y");
		flush_run(1'b1);	// no bytes at all
		run_buf.push_back("a");
		run_buf.push_back("b");
		flush_run(1'b1);	// bytes closed by the empty flag
		fill_random(100);
		wait_drained();

		// phase 2: sender idle
		send_idle = 54;
		recv_stall = 0;
		fill_random(100);
		wait_drained();

		// phase 3: receiver stalls
		send_idle = 0;
		recv_stall = 54;
		fill_random(100);
		wait_drained();

		// phase 4: light idling on both sides
		send_idle = 10;
		recv_stall = 10;
		fill_random(100);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("** url_path_component_splitter_top: PASSED **");
		else
			$display("** url_path_component_splitter_top: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("** url_path_component_splitter_top: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/usplit_pkg.sv
rtl/usplit_front.sv
rtl/usplit_fifo.sv
rtl/usplit_back.sv
rtl/url_path_component_splitter_top.sv
verif/tb_url_path_component_splitter_top.sv
